>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL of the rand48 draw block.
// Needs clk and arst_n in the scope of every use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`define ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/lcg48_pkg.sv
// Shared types and constants of the rand48 draw block.
// No dependencies.
package lcg48_pkg;

	localparam int STATE_W  = 48;
	localparam int DRAW_W   = 31;
	localparam int WORD_W   = 32;
	localparam int ADDEND_W = 16;
	localparam int CFG_IDX_W = 2;

	localparam logic [STATE_W-1:0]  STATE_RESET  = 48'h1234_ABCD_330E;
	localparam logic [STATE_W-1:0]  MULT_RESET   = 48'h0005_DEEC_E66D;
	localparam logic [ADDEND_W-1:0] ADDEND_RESET = 16'h000B;
	localparam logic [15:0]         SEED_LOW     = 16'h330E;

	localparam logic [CFG_IDX_W-1:0] REG_SEED   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MULT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ADDEND = 2'd2;

	typedef struct packed {
		logic              use_range;
		logic              span_error;
		logic [DRAW_W-1:0] draw;
		logic [WORD_W-1:0] range_start;
		logic [WORD_W-1:0] span;
	} lcg_rec_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_MUL,
		F_SUM,
		F_PUSH
	} front_state_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_RUN,
		B_DONE
	} back_state_t;

endpackage

>>> rtl/lcg48_front.sv
// Front end: takes draw requests, advances the 48-bit generator state over
// partial products and classifies the range. Depends on lcg48_pkg.
module lcg48_front import lcg48_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic                 use_range,
	input  logic signed [31:0]   range_start,
	input  logic signed [31:0]   range_end,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [STATE_W-1:0]   cfg_data,
	output logic                 q_push,
	input  logic                 q_full,
	output lcg_rec_t             rec
);

	front_state_t        fstate_q, fstate_d;
	logic [STATE_W-1:0]  mult_q;
	logic [ADDEND_W-1:0] addend_q;
	logic [STATE_W-1:0]  gen_q;
	logic                use_q;
	logic [WORD_W-1:0]   start_q, end_q;
	logic [STATE_W-1:0]  plo_s1;
	logic [15:0]         cross_s1;
	lcg_rec_t            rec_q;

	logic [63:0]         plo_full;
	logic [31:0]         xa, xb;
	logic [STATE_W-1:0]  gen_next;
	logic [WORD_W:0]     span33;
	logic                accept;

	assign accept   = push && !full;
	assign plo_full = mult_q[31:0] * gen_q[31:0];
	assign xa       = mult_q[15:0] * gen_q[47:32];
	assign xb       = mult_q[47:32] * gen_q[15:0];
	assign gen_next = plo_s1 + {cross_s1, 32'd0} + {32'd0, addend_q};
	assign span33   = {end_q[WORD_W-1], end_q} - {start_q[WORD_W-1], start_q};

	always_comb begin
		fstate_d = fstate_q;
		unique case (fstate_q)
			F_IDLE: if (push) fstate_d = F_MUL;
			F_MUL:  fstate_d = F_SUM;
			F_SUM:  fstate_d = F_PUSH;
			F_PUSH: if (!q_full) fstate_d = F_IDLE;
			default: fstate_d = F_IDLE;
		endcase
	end

	always_comb begin
		full   = (fstate_q != F_IDLE);
		q_push = (fstate_q == F_PUSH) && !q_full;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fstate_q <= F_IDLE;
			mult_q   <= MULT_RESET;
			addend_q <= ADDEND_RESET;
			gen_q    <= STATE_RESET;
		end else begin
			fstate_q <= fstate_d;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_SEED:   gen_q <= {cfg_data[31:0], SEED_LOW};
					REG_MULT:   mult_q <= cfg_data;
					REG_ADDEND: addend_q <= cfg_data[ADDEND_W-1:0];
					default: ;
				endcase
			end else if (fstate_q == F_SUM) begin
				gen_q <= gen_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			use_q   <= use_range;
			start_q <= range_start;
			end_q   <= range_end;
		end
		if (fstate_q == F_MUL) begin
			plo_s1   <= plo_full[STATE_W-1:0];
			cross_s1 <= xa[15:0] + xb[15:0];
		end
		if (fstate_q == F_SUM) begin
			rec_q.use_range   <= use_q;
			rec_q.span_error  <= use_q && (span33[WORD_W] || (span33 == '0));
			rec_q.draw        <= gen_next[STATE_W-1:STATE_W-DRAW_W];
			rec_q.range_start <= start_q;
			rec_q.span        <= span33[WORD_W-1:0];
		end
	end

	assign rec = rec_q;

endmodule

>>> rtl/lcg48_queue.sv
// Two-entry queue of classified draws between front and back end.
// Depends on lcg48_pkg.
module lcg48_queue import lcg48_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     q_push,
	input  lcg_rec_t wr_rec,
	output logic     q_full,
	input  logic     q_pop,
	output logic     q_empty,
	output lcg_rec_t rd_rec
);

	lcg_rec_t   entry_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;

	assign q_full  = (count_q == 2'd2);
	assign q_empty = (count_q == 2'd0);
	assign rd_rec  = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (q_push) wr_ptr_q <= !wr_ptr_q;
			if (q_pop) rd_ptr_q <= !rd_ptr_q;
			priority if (q_push && !q_pop) count_q <= count_q + 2'd1;
			else if (q_pop && !q_push) count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (q_push) entry_q[wr_ptr_q] <= wr_rec;
	end

endmodule

>>> rtl/lcg48_back.sv
// Back end: bit-serial remainder of the draw by the span, offset by the
// range start, and the result register. Depends on lcg48_pkg.
module lcg48_back import lcg48_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	input  lcg_rec_t           rd_rec,
	output logic               q_pop,
	output logic               empty,
	input  logic               pop,
	output logic signed [31:0] value,
	output logic               span_error
);

	back_state_t       bstate_q, bstate_d;
	logic [DRAW_W-1:0] draw_q;
	logic [WORD_W-1:0] start_q, span_q, rem_q;
	logic [4:0]        cnt_q;
	logic [WORD_W-1:0] res_value_q;
	logic              res_err_q;
	logic              out_valid_q;
	logic [WORD_W-1:0] value_q;
	logic              err_q;

	logic [WORD_W:0]   shifted;
	logic [WORD_W+1:0] diff;
	logic [WORD_W-1:0] rem_next;
	logic              load_out;

	assign shifted  = {rem_q, draw_q[DRAW_W-1]};
	assign diff     = {1'b0, shifted} - {2'b00, span_q};
	assign rem_next = diff[WORD_W+1] ? shifted[WORD_W-1:0] : diff[WORD_W-1:0];

	always_comb begin
		bstate_d = bstate_q;
		unique case (bstate_q)
			B_IDLE: begin
				if (!q_empty) begin
					if (rd_rec.use_range && !rd_rec.span_error) bstate_d = B_RUN;
					else bstate_d = B_DONE;
				end
			end
			B_RUN:  if (cnt_q == 5'd0) bstate_d = B_DONE;
			B_DONE: if (load_out) bstate_d = B_IDLE;
			default: bstate_d = B_IDLE;
		endcase
	end

	always_comb begin
		q_pop    = (bstate_q == B_IDLE) && !q_empty;
		load_out = (bstate_q == B_DONE) && (!out_valid_q || pop);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bstate_q    <= B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			bstate_q <= bstate_d;
			priority if (load_out) out_valid_q <= 1'b1;
			else if (pop) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			draw_q  <= rd_rec.draw;
			start_q <= rd_rec.range_start;
			span_q  <= rd_rec.span;
			rem_q   <= '0;
			cnt_q   <= 5'(DRAW_W - 1);
			priority if (!rd_rec.use_range) begin
				res_value_q <= {1'b0, rd_rec.draw};
				res_err_q   <= 1'b0;
			end else if (rd_rec.span_error) begin
				res_value_q <= '0;
				res_err_q   <= 1'b1;
			end else begin
				res_err_q <= 1'b0;
			end
		end
		if (bstate_q == B_RUN) begin
			rem_q  <= rem_next;
			draw_q <= {draw_q[DRAW_W-2:0], 1'b0};
			cnt_q  <= cnt_q - 5'd1;
			if (cnt_q == 5'd0) res_value_q <= rem_next + start_q;
		end
		if (load_out) begin
			value_q <= res_value_q;
			err_q   <= res_err_q;
		end
	end

	assign empty      = !out_valid_q;
	assign value      = value_q;
	assign span_error = err_q;

endmodule

>>> rtl/lcg48_random_draw.sv
// rand48 draw block: front end, two-entry queue, bit-serial remainder back end.
// The front end takes a new request only when idle; the two-entry queue lets it run
// ahead of the back end. Range draws pass the one-bit-per-cycle remainder loop.
// Reset: state 0x1234ABCD330E, multiplier 0x5DEECE66D, addend 0xB, queue and
// result register empty.
`include "assert_macros.svh"

module lcg48_random_draw import lcg48_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic                 use_range,
	input  logic signed [31:0]   range_start,
	input  logic signed [31:0]   range_end,
	output logic                 empty,
	input  logic                 pop,
	output logic signed [31:0]   value,
	output logic                 span_error,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [STATE_W-1:0]   cfg_data
);

	logic     q_push, q_full, q_pop, q_empty;
	lcg_rec_t wr_rec, rd_rec;

	lcg48_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.use_range   (use_range),
		.range_start (range_start),
		.range_end   (range_end),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.q_push      (q_push),
		.q_full      (q_full),
		.rec         (wr_rec)
	);

	lcg48_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_push  (q_push),
		.wr_rec  (wr_rec),
		.q_full  (q_full),
		.q_pop   (q_pop),
		.q_empty (q_empty),
		.rd_rec  (rd_rec)
	);

	lcg48_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.rd_rec     (rd_rec),
		.q_pop      (q_pop),
		.empty      (empty),
		.pop        (pop),
		.value      (value),
		.span_error (span_error)
	);

	`ASSERT_NEVER(a_queue_overflow, q_push && q_full, "transfer into full queue")
	`ASSERT_NEVER(a_queue_underflow, q_pop && q_empty, "transfer out of empty queue")
	`ASSERT_IMPLY(a_err_zero, !empty && span_error, value == 32'sd0, "span error with value")
	`ASSERT_NEXT(a_front_busy, push && !full, full, "front idle after accepted transfer")

endmodule
